/* hw/rtl/wqvs_pkg.sv */
// ----------------------------------------------------------------------------
// wqvs_pkg - shared types and constants for the quaternion skinning core
// Fixed-point formats, operand widths, and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package wqvs_pkg;

  // fixed-point formats
  localparam int QUAT_FRAC = 14;     // quaternion parts, Q1.14
  localparam int BIAS_FRAC = 15;     // bias, Q1.15

  // field widths
  localparam int P_W   = 32;         // positions, Q16.16
  localparam int Q_W   = 16;         // quaternion parts
  localparam int B_W   = 16;         // bias
  localparam int OUT_W = 32;         // vertex output

  // internal widths, sized from worst-case magnitudes
  localparam int T_W    = 35;        // |p*q| <= 3*2^32
  localparam int R_W    = 38;        // |conj(q)*t| <= 12*2^33, also holds joint + r
  localparam int OPA_W  = 38;        // MAC operand A
  localparam int OPB_W  = 17;        // MAC operand B (negated q, or unsigned bias)
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int TERM_W = 39;        // biased term after rounding
  localparam int SUM_W  = TERM_W + 1;

  localparam int LANES = 4;          // x, y, z, w
  localparam int AXES  = 3;          // x, y, z

  typedef enum logic [1:0] {
    OP_T,                            // t = p * q
    OP_R,                            // r = conj(q) * t
    OP_B                             // (joint + r) * bias
  } mac_op_t;

  typedef struct packed {
    logic    load;                   // capture an input word
    logic    mac_en;                 // lanes multiply-accumulate
    mac_op_t op;
    logic [1:0] step;
    logic    first;                  // start a new accumulation
    logic    fin;                    // round and store the lane result
    logic    upd;                    // add biased term into the sums
    logic    emit;                   // load output, clear sums
  } dp_cmd_t;

  typedef struct packed {
    logic last;                      // current weight closes the vertex
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/wqvs_datapath.sv */
// ----------------------------------------------------------------------------
// wqvs_datapath - four MAC lanes, rounding, saturating accumulators
// Operand registers, shared multipliers, and the vertex output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wqvs_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire wqvs_pkg::dp_cmd_t              cmd,
  input  wire logic signed [15:0]             rot_x,
  input  wire logic signed [15:0]             rot_y,
  input  wire logic signed [15:0]             rot_z,
  input  wire logic signed [15:0]             rot_w,
  input  wire logic signed [31:0]             joint_x,
  input  wire logic signed [31:0]             joint_y,
  input  wire logic signed [31:0]             joint_z,
  input  wire logic signed [31:0]             offset_x,
  input  wire logic signed [31:0]             offset_y,
  input  wire logic signed [31:0]             offset_z,
  input  wire logic        [15:0]             bias,
  input  wire logic                           last_weight,
  output wqvs_pkg::dp_stat_t                  stat,
  output logic signed [31:0]                  vert_x,
  output logic signed [31:0]                  vert_y,
  output logic signed [31:0]                  vert_z
);
  import wqvs_pkg::*;

  // operand registers
  logic signed [Q_W-1:0]    qx_r, qy_r, qz_r, qw_r;
  logic signed [P_W-1:0]    px_r, py_r, pz_r;
  logic signed [P_W-1:0]    j_r   [AXES];
  logic        [B_W-1:0]    b_r;
  logic                     last_r;

  // working registers
  logic signed [ACC_W-1:0]  acc_r [LANES];
  logic signed [T_W-1:0]    t_r   [LANES];   // 0..3 = tx, ty, tz, tw
  logic signed [R_W-1:0]    r_r   [AXES];
  logic signed [OUT_W-1:0]  sum_r [AXES];
  logic signed [OUT_W-1:0]  out_r [AXES];

  logic signed [OPA_W-1:0]  a_sel   [LANES];
  logic signed [OPB_W-1:0]  b_sel   [LANES];
  logic signed [PROD_W-1:0] prod    [LANES];
  logic signed [ACC_W-1:0]  acc_sum [LANES];
  logic signed [ACC_W-1:0]  acc_rnd [LANES];
  logic signed [ACC_W-1:0]  b_rnd   [AXES];
  logic signed [SUM_W-1:0]  sum_new [AXES];
  logic signed [OUT_W-1:0]  sum_sat [AXES];

  function automatic logic signed [OPB_W-1:0] qpos(input logic signed [Q_W-1:0] v);
    return OPB_W'(v);
  endfunction

  function automatic logic signed [OPB_W-1:0] qneg(input logic signed [Q_W-1:0] v);
    return -OPB_W'(v);
  endfunction

  // operand steering per phase and step
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a_sel[i] = '0;
      b_sel[i] = '0;
    end
    unique case (cmd.op)
      OP_T: begin
        // lanes tx, ty, tz, tw; step k walks px, py, pz
        unique case (cmd.step)
          2'd0: begin
            for (int i = 0; i < LANES; i++) a_sel[i] = OPA_W'(px_r);
            b_sel[0] = qpos(qw_r); b_sel[1] = qneg(qz_r);
            b_sel[2] = qpos(qy_r); b_sel[3] = qneg(qx_r);
          end
          2'd1: begin
            for (int i = 0; i < LANES; i++) a_sel[i] = OPA_W'(py_r);
            b_sel[0] = qpos(qz_r); b_sel[1] = qpos(qw_r);
            b_sel[2] = qneg(qx_r); b_sel[3] = qneg(qy_r);
          end
          default: begin
            for (int i = 0; i < LANES; i++) a_sel[i] = OPA_W'(pz_r);
            b_sel[0] = qneg(qy_r); b_sel[1] = qpos(qx_r);
            b_sel[2] = qpos(qw_r); b_sel[3] = qneg(qz_r);
          end
        endcase
      end
      OP_R: begin
        // lanes rx, ry, rz; step k walks qw, qx, qy, qz
        unique case (cmd.step)
          2'd0: begin
            a_sel[0] = OPA_W'(t_r[0]); b_sel[0] = qpos(qw_r);
            a_sel[1] = OPA_W'(t_r[1]); b_sel[1] = qpos(qw_r);
            a_sel[2] = OPA_W'(t_r[2]); b_sel[2] = qpos(qw_r);
          end
          2'd1: begin
            a_sel[0] = OPA_W'(t_r[3]); b_sel[0] = qneg(qx_r);
            a_sel[1] = OPA_W'(t_r[2]); b_sel[1] = qpos(qx_r);
            a_sel[2] = OPA_W'(t_r[1]); b_sel[2] = qneg(qx_r);
          end
          2'd2: begin
            a_sel[0] = OPA_W'(t_r[2]); b_sel[0] = qneg(qy_r);
            a_sel[1] = OPA_W'(t_r[3]); b_sel[1] = qneg(qy_r);
            a_sel[2] = OPA_W'(t_r[0]); b_sel[2] = qpos(qy_r);
          end
          default: begin
            a_sel[0] = OPA_W'(t_r[1]); b_sel[0] = qpos(qz_r);
            a_sel[1] = OPA_W'(t_r[0]); b_sel[1] = qneg(qz_r);
            a_sel[2] = OPA_W'(t_r[3]); b_sel[2] = qneg(qz_r);
          end
        endcase
      end
      OP_B: begin
        for (int i = 0; i < AXES; i++) begin
          a_sel[i] = OPA_W'(j_r[i]) + OPA_W'(r_r[i]);
          b_sel[i] = OPB_W'({1'b0, b_r});
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod[i]    = a_sel[i] * b_sel[i];
      acc_sum[i] = (cmd.first ? ACC_W'(0) : acc_r[i]) + ACC_W'(prod[i]);
      acc_rnd[i] = acc_sum[i] + (ACC_W'(1) <<< (QUAT_FRAC - 1));
    end
    for (int i = 0; i < AXES; i++) begin
      b_rnd[i]   = acc_r[i] + (ACC_W'(1) <<< (BIAS_FRAC - 1));
      sum_new[i] = SUM_W'(sum_r[i]) + SUM_W'(signed'(b_rnd[i][BIAS_FRAC +: TERM_W]));
      // clamp to the 32-bit output range
      if (sum_new[i][SUM_W-1:OUT_W-1] == '0 || sum_new[i][SUM_W-1:OUT_W-1] == '1)
        sum_sat[i] = sum_new[i][OUT_W-1:0];
      else
        sum_sat[i] = sum_new[i][SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qx_r   <= rot_x;
      qy_r   <= rot_y;
      qz_r   <= rot_z;
      qw_r   <= rot_w;
      px_r   <= offset_x;
      py_r   <= offset_y;
      pz_r   <= offset_z;
      j_r[0] <= joint_x;
      j_r[1] <= joint_y;
      j_r[2] <= joint_z;
      b_r    <= bias;
      last_r <= last_weight;
    end
    if (cmd.mac_en) begin
      for (int i = 0; i < LANES; i++) acc_r[i] <= acc_sum[i];
      if (cmd.fin && cmd.op == OP_T) begin
        for (int i = 0; i < LANES; i++) t_r[i] <= acc_rnd[i][QUAT_FRAC +: T_W];
      end
      if (cmd.fin && cmd.op == OP_R) begin
        for (int i = 0; i < AXES; i++) r_r[i] <= acc_rnd[i][QUAT_FRAC +: R_W];
      end
    end
    if (cmd.emit) begin
      for (int i = 0; i < AXES; i++) out_r[i] <= sum_sat[i];
    end
  end

  // vertex accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) sum_r[i] <= '0;
    end else if (cmd.upd) begin
      for (int i = 0; i < AXES; i++) sum_r[i] <= cmd.emit ? '0 : sum_sat[i];
    end
  end

  assign stat.last = last_r;
  assign vert_x    = out_r[0];
  assign vert_y    = out_r[1];
  assign vert_z    = out_r[2];

endmodule

`default_nettype wire

/* hw/rtl/wqvs_ctrl.sv */
// ----------------------------------------------------------------------------
// wqvs_ctrl - sequencer for the quaternion skinning datapath
// Walks the product, rotation, bias and accumulate phases; owns handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module wqvs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire wqvs_pkg::dp_stat_t stat,
  output wqvs_pkg::dp_cmd_t       cmd
);
  import wqvs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_T,          // p * q, three steps
    ST_R,          // conj(q) * t, four steps
    ST_B,          // bias multiply
    ST_S           // accumulate, maybe emit
  } state_t;

  state_t     state_r;
  logic [1:0] step_r;
  logic       out_valid_r;
  logic       finish;
  logic       accept;

  // a non-final weight always retires; a final one needs the output slot
  assign finish    = (state_r == ST_S) && (!stat.last || !out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE) || finish;
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.op     = OP_T;
    cmd.step   = step_r;
    cmd.load   = accept;
    cmd.upd    = finish;
    cmd.emit   = finish && stat.last;
    unique case (state_r)
      ST_T: begin
        cmd.mac_en = 1'b1;
        cmd.op     = OP_T;
        cmd.first  = (step_r == 2'd0);
        cmd.fin    = (step_r == 2'd2);
      end
      ST_R: begin
        cmd.mac_en = 1'b1;
        cmd.op     = OP_R;
        cmd.first  = (step_r == 2'd0);
        cmd.fin    = (step_r == 2'd3);
      end
      ST_B: begin
        cmd.mac_en = 1'b1;
        cmd.op     = OP_B;
        cmd.first  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_T;
            step_r  <= '0;
          end
        end
        ST_T: begin
          if (step_r == 2'd2) begin
            state_r <= ST_R;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        ST_R: begin
          if (step_r == 2'd3) begin
            state_r <= ST_B;
            step_r  <= '0;
          end else begin
            step_r <= step_r + 2'd1;
          end
        end
        ST_B: begin
          state_r <= ST_S;
        end
        ST_S: begin
          if (finish) begin
            state_r <= accept ? ST_T : ST_IDLE;
            step_r  <= '0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
          step_r  <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/weighted_quaternion_vertex_skinning_core.sv */
// ----------------------------------------------------------------------------
// weighted_quaternion_vertex_skinning_core - md5mesh-style vertex skinning
// Accumulates bias-weighted, quaternion-rotated joint offsets per vertex.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one word per vertex weight (quaternion, joint position,
//   offset, bias); in_tlast marks the final weight of a vertex. The offset
//   is rotated as conj(q)*p*q, joint position added, scaled by bias, and
//   summed into saturating Q16.16 accumulators.
//   Output stream: one word per vertex, issued after its tlast weight.
// Timing:
//   Each weight occupies the four shared MAC lanes in turn for p*q, then
//   conj(q)*t, then the bias product, then the accumulate step.
//   The next word is taken in the accumulate cycle, so weights do not
//   overlap. out_tvalid is registered from the emit in the accumulate
//   cycle of the tlast weight.
// Reset / stall:
//   Synchronous reset clears the accumulators and all handshake state.
//   A finished vertex sits in the output register; weights of the next
//   vertex keep flowing while it waits. Only a second tlast weight stalls,
//   in its accumulate cycle, until the pending vertex is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_quaternion_vertex_skinning_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // rot_x, rot_y, rot_z, rot_w, joint_x, joint_y, joint_z,
  // offset_x, offset_y, offset_z, bias (from bit 0 up)
  input  wire logic [271:0] in_tdata,
  input  wire logic         in_tlast,     // last_weight
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // vert_x, vert_y, vert_z (from bit 0 up)
  output logic [95:0]       out_tdata
);
  import wqvs_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic signed [OUT_W-1:0] vert_x, vert_y, vert_z;

  wqvs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (dp_stat),
    .cmd        (dp_cmd)
  );

  wqvs_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .rot_x       (in_tdata[15:0]),
    .rot_y       (in_tdata[31:16]),
    .rot_z       (in_tdata[47:32]),
    .rot_w       (in_tdata[63:48]),
    .joint_x     (in_tdata[95:64]),
    .joint_y     (in_tdata[127:96]),
    .joint_z     (in_tdata[159:128]),
    .offset_x    (in_tdata[191:160]),
    .offset_y    (in_tdata[223:192]),
    .offset_z    (in_tdata[255:224]),
    .bias        (in_tdata[271:256]),
    .last_weight (in_tlast),
    .stat        (dp_stat),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .vert_z      (vert_z)
  );

  assign out_tdata = {vert_z, vert_y, vert_x};

  // ---- assertions ----

  // a weight is in flight through the MAC phases after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken during MAC phase");

  // a vertex is never written over a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> (!out_tvalid || out_tready))
    else $error("pending vertex overwritten");

  // new results only come from a weight flagged last
  a_emit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(dp_stat.last))
    else $error("vertex emitted without last weight");

endmodule

`default_nettype wire
